/* design/rsdc_pkg.sv */
// rsdc_pkg: shared types, register codes, reset values and fixed-point helpers
// for the rss safe-distance check pipeline
// depends on nothing; used by every module of the block
package rsdc_pkg;

   localparam int FRAC_BITS = 16;
   localparam int VAL_W     = 31;
   localparam int IN_W      = 32;
   localparam int CSR_IDX_W = 8;

   localparam logic [VAL_W-1:0] SAT31 = '1;

   typedef logic [VAL_W-1:0] mag_type;

   // register index codes, in register-list order
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_REACT_TIME         = 8'd0,
      REG_LON_ACCEL_MAX      = 8'd1,
      REG_LON_BRAKE_MIN_HREC = 8'd2,
      REG_LON_BRAKE_MAX_HREC = 8'd3,
      REG_LAT_ACCEL_MAX      = 8'd4,
      REG_LAT_BRAKE_MIN_HREC = 8'd5,
      REG_LAT_BRAKE_MAX_HREC = 8'd6,
      REG_LAT_MARGIN         = 8'd7
   } reg_idx_type;

   typedef struct packed {
      mag_type react_time;
      mag_type lon_accel_max;
      mag_type lon_brake_min_half_recip;
      mag_type lon_brake_max_half_recip;
      mag_type lat_accel_max;
      mag_type lat_brake_min_half_recip;
      mag_type lat_brake_max_half_recip;
      mag_type lat_margin;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      react_time:               31'd32768,
      lon_accel_max:            31'd131072,
      lon_brake_min_half_recip: 31'd8192,
      lon_brake_max_half_recip: 31'd4096,
      lat_accel_max:            31'd13107,
      lat_brake_min_half_recip: 31'd40960,
      lat_brake_max_half_recip: 31'd40960,
      lat_margin:               31'd6554
   };

   // per-pair flags and gaps carried alongside the lanes
   typedef struct packed {
      logic              ego_lon_neg;
      logic              oth_lon_neg;
      logic              ego_lat_neg;
      logic              oth_lat_neg;
      logic              ego_behind;   // ego lon pos strictly below other
      logic              ego_lat_ge;   // ego lat pos at or above other
      logic [IN_W-1:0]   gap_lon;
      logic [IN_W-1:0]   gap_lat;
   } side_type;

   typedef struct packed {
      mag_type passive;
      mag_type active;
   } dist_type;

   typedef struct packed {
      logic    is_safe;
      mag_type safe_lon;
      mag_type safe_lat;
   } result_type;

   function automatic mag_type sat32(input logic [IN_W-1:0] x);
      return x[IN_W-1] ? SAT31 : x[VAL_W-1:0];
   endfunction

   function automatic mag_type add_sat(input mag_type a, input mag_type b);
      logic [IN_W-1:0] s;
      s = {1'b0, a} + {1'b0, b};
      return sat32(s);
   endfunction

   function automatic mag_type clamp_diff(input mag_type a, input mag_type b);
      return (a > b) ? mag_type'(a - b) : '0;
   endfunction

   function automatic mag_type mag_of(input logic signed [IN_W-1:0] v);
      logic [IN_W-1:0] u;
      u = v[IN_W-1] ? (~v + 32'd1) : v;
      return sat32(u);
   endfunction

   // q product, truncated and saturated
   function automatic mag_type mulq(input mag_type a, input mag_type b);
      logic [2*VAL_W-1:0] p;
      logic [2*VAL_W-1:0] s;
      p = (2*VAL_W)'(a) * (2*VAL_W)'(b);
      s = p >> FRAC_BITS;
      return (|s[2*VAL_W-1:VAL_W]) ? SAT31 : s[VAL_W-1:0];
   endfunction

   // average-speed travel: (v + v_resp) * t, one extra bit of shift
   function automatic mag_type mul_travel(input logic [IN_W-1:0] v, input mag_type t);
      logic [IN_W+VAL_W-1:0] p;
      logic [IN_W+VAL_W-1:0] s;
      p = (IN_W+VAL_W)'(v) * (IN_W+VAL_W)'(t);
      s = p >> (FRAC_BITS + 1);
      return (|s[IN_W+VAL_W-1:VAL_W]) ? SAT31 : s[VAL_W-1:0];
   endfunction

endpackage

/* design/rsdc_csr.sv */
// rsdc_csr: configuration register file of the safe-distance check
// depends on rsdc_pkg (cfg_type, register codes, reset values)
module rsdc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rsdc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rsdc_pkg::VAL_W-1:0]     csr_data,
   output rsdc_pkg::cfg_type             cfg
);

   rsdc_pkg::cfg_type cfg_ff;
   rsdc_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (rsdc_pkg::reg_idx_type'(csr_index))
            rsdc_pkg::REG_REACT_TIME:         cfg_in.react_time               = csr_data;
            rsdc_pkg::REG_LON_ACCEL_MAX:      cfg_in.lon_accel_max            = csr_data;
            rsdc_pkg::REG_LON_BRAKE_MIN_HREC: cfg_in.lon_brake_min_half_recip = csr_data;
            rsdc_pkg::REG_LON_BRAKE_MAX_HREC: cfg_in.lon_brake_max_half_recip = csr_data;
            rsdc_pkg::REG_LAT_ACCEL_MAX:      cfg_in.lat_accel_max            = csr_data;
            rsdc_pkg::REG_LAT_BRAKE_MIN_HREC: cfg_in.lat_brake_min_half_recip = csr_data;
            rsdc_pkg::REG_LAT_BRAKE_MAX_HREC: cfg_in.lat_brake_max_half_recip = csr_data;
            rsdc_pkg::REG_LAT_MARGIN:         cfg_in.lat_margin               = csr_data;
            default: ;   // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= rsdc_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* design/rsdc_lane.sv */
// rsdc_lane: passive and active stopping distance for one speed, stages 2 to 5
// depends on rsdc_pkg (mulq, mul_travel, add_sat, dist_type)
module rsdc_lane (
   input  logic                  clock,
   input  logic [3:0]            stage_en,        // bit 0 loads stage 2
   input  rsdc_pkg::mag_type     vabs,            // stage 1 speed magnitude
   input  rsdc_pkg::mag_type     accel_resp,      // stage 1 accel * response time
   input  rsdc_pkg::mag_type     resp_time,
   input  rsdc_pkg::mag_type     brake_min_recip,
   input  rsdc_pkg::mag_type     brake_max_recip,
   output rsdc_pkg::dist_type    stop_dist
);

   // stage 2
   rsdc_pkg::mag_type  vabs2_ff, vr_ff, vsq_ff;
   rsdc_pkg::mag_type  vr_in, vsq_in;
   // stage 3
   logic [rsdc_pkg::IN_W-1:0] vsum_ff, vsum_in;
   rsdc_pkg::mag_type  vrsq_ff, act3_ff;
   rsdc_pkg::mag_type  vrsq_in, act3_in;
   // stage 4
   rsdc_pkg::mag_type  travel_ff, brk_ff, act4_ff;
   rsdc_pkg::mag_type  travel_in, brk_in;
   // stage 5
   rsdc_pkg::dist_type dist_ff, dist_in;

   always_comb begin
      vr_in          = rsdc_pkg::add_sat(vabs, accel_resp);
      vsq_in         = rsdc_pkg::mulq(vabs, vabs);
      vsum_in        = {1'b0, vabs2_ff} + {1'b0, vr_ff};
      vrsq_in        = rsdc_pkg::mulq(vr_ff, vr_ff);
      act3_in        = rsdc_pkg::mulq(vsq_ff, brake_max_recip);
      travel_in      = rsdc_pkg::mul_travel(vsum_ff, resp_time);
      brk_in         = rsdc_pkg::mulq(vrsq_ff, brake_min_recip);
      dist_in.passive = rsdc_pkg::add_sat(travel_ff, brk_ff);
      dist_in.active  = act4_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         vabs2_ff <= vabs;
         vr_ff    <= vr_in;
         vsq_ff   <= vsq_in;
      end
      if (stage_en[1]) begin
         vsum_ff  <= vsum_in;
         vrsq_ff  <= vrsq_in;
         act3_ff  <= act3_in;
      end
      if (stage_en[2]) begin
         travel_ff <= travel_in;
         brk_ff    <= brk_in;
         act4_ff   <= act3_ff;
      end
      if (stage_en[3]) begin
         dist_ff <= dist_in;
      end
   end

   assign stop_dist = dist_ff;

endmodule

/* design/rsdc_decide.sv */
// rsdc_decide: case selection of safe distances, margin and gap compare,
// stages 6 and 7; depends on rsdc_pkg (side_type, dist_type, result_type)
module rsdc_decide (
   input  logic                  clock,
   input  logic [1:0]            stage_en,     // bit 0 loads stage 6
   input  rsdc_pkg::side_type    side,
   input  rsdc_pkg::dist_type    ego_lon,
   input  rsdc_pkg::dist_type    oth_lon,
   input  rsdc_pkg::dist_type    ego_lat,
   input  rsdc_pkg::dist_type    oth_lat,
   input  rsdc_pkg::mag_type     lat_margin,
   output rsdc_pkg::result_type  result
);

   rsdc_pkg::mag_type         slon_ff, slon_in;
   rsdc_pkg::mag_type         slat_pre_ff, slat_pre_in;
   logic [rsdc_pkg::IN_W-1:0] gap_lon_ff, gap_lat_ff;
   rsdc_pkg::result_type      result_ff, result_in;
   rsdc_pkg::mag_type         slat;

   always_comb begin
      slon_in = '0;
      if (side.ego_behind) begin
         if (!side.ego_lon_neg) begin
            slon_in = side.oth_lon_neg
                    ? rsdc_pkg::add_sat(ego_lon.passive, oth_lon.passive)
                    : rsdc_pkg::clamp_diff(ego_lon.passive, oth_lon.active);
         end
      end else if (!side.ego_lon_neg && !side.oth_lon_neg) begin
         slon_in = rsdc_pkg::clamp_diff(oth_lon.passive, ego_lon.active);
      end

      case ({side.ego_lat_ge, side.ego_lat_neg, side.oth_lat_neg})
         3'b100:  slat_pre_in = rsdc_pkg::clamp_diff(oth_lat.passive, ego_lat.active);
         3'b111:  slat_pre_in = rsdc_pkg::clamp_diff(ego_lat.passive, oth_lat.active);
         3'b110:  slat_pre_in = rsdc_pkg::add_sat(ego_lat.passive, oth_lat.passive);
         3'b000:  slat_pre_in = rsdc_pkg::clamp_diff(ego_lat.passive, oth_lat.active);
         3'b001:  slat_pre_in = rsdc_pkg::add_sat(ego_lat.passive, oth_lat.passive);
         3'b011:  slat_pre_in = rsdc_pkg::clamp_diff(oth_lat.passive, ego_lat.active);
         default: slat_pre_in = '0;   // moving apart laterally
      endcase
   end

   always_comb begin
      slat               = rsdc_pkg::add_sat(slat_pre_ff, lat_margin);
      result_in.safe_lon = slon_ff;
      result_in.safe_lat = slat;
      result_in.is_safe  = !((gap_lon_ff < {1'b0, slon_ff}) && (gap_lat_ff < {1'b0, slat}));
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         slon_ff     <= slon_in;
         slat_pre_ff <= slat_pre_in;
         gap_lon_ff  <= side.gap_lon;
         gap_lat_ff  <= side.gap_lat;
      end
      if (stage_en[1]) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

/* design/rss_safe_distance_check_top.sv */
// rss_safe_distance_check_top: seven-stage rss safe-distance check
// depends on rsdc_pkg, rsdc_csr, rsdc_lane, rsdc_decide
//
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  req_tdata  eight 32-bit signed q fields
//  rsp      out  rsp_tvalid/rsp_tready  rsp_tdata  is_safe, safe lon, safe lat
//  csr      in   csr_valid/csr_ready    csr_index, csr_data (31 bits)
//
//  one beat per cycle in and out while rsp_tready is held high; rsp_tvalid rises
//  once an accepted beat has passed through the stage 1 to stage 7 registers
//  the pipeline depth is set by the lane multiplier chain: speed squared, then the
//  response-speed square, then the reciprocal and travel products, each behind
//  a register
//  every stage has its own ready, so bubbles close up and req keeps flowing
//  while a result waits on rsp, until all seven stages hold a beat
//  reset clears the valid bits and loads the register reset values; csr is
//  always ready
module rss_safe_distance_check_top (
   input  logic                           clock,
   input  logic                           reset,
   // req_tdata from bit 0: ego_lon_pos, ego_lon_vel, ego_lat_pos, ego_lat_vel,
   // other_lon_pos, other_lon_vel, other_lat_pos, other_lat_vel (32 bits each)
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [255:0]                   req_tdata,
   // rsp_tdata from bit 0: is_safe (1), safe lon distance (31),
   // safe lat distance (31), one zero pad bit
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [63:0]                    rsp_tdata,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rsdc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rsdc_pkg::VAL_W-1:0]     csr_data
);

   rsdc_pkg::cfg_type cfg;

   rsdc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // ---------------- stage valid bits and per-stage ready ----------------
   logic [7:1] v_ff, v_in;
   logic [8:1] en;           // en[k]: stage k register may load

   always_comb begin
      en[8] = rsp_tready;
      for (int k = 7; k >= 1; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      v_in[1] = en[1] ? req_tvalid : v_ff[1];
      for (int k = 2; k <= 7; k++) begin
         v_in[k] = en[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_tready = en[1];
   assign rsp_tvalid = v_ff[7];

   // ---------------- stage 1: magnitudes, ordering, gaps ----------------
   logic signed [31:0] ego_lon_pos, ego_lon_vel, ego_lat_pos, ego_lat_vel;
   logic signed [31:0] oth_lon_pos, oth_lon_vel, oth_lat_pos, oth_lat_vel;
   logic signed [32:0] d_lon, d_lat, d_lon_neg, d_lat_neg;
   rsdc_pkg::side_type side_in;
   rsdc_pkg::side_type side_ff [1:5];
   rsdc_pkg::mag_type  vabs_in [4];
   rsdc_pkg::mag_type  vabs_ff [4];   // ego lon, other lon, ego lat, other lat
   rsdc_pkg::mag_type  ar_lon_in, ar_lat_in, ar_lon_ff, ar_lat_ff;

   always_comb begin
      ego_lon_pos = req_tdata[31:0];
      ego_lon_vel = req_tdata[63:32];
      ego_lat_pos = req_tdata[95:64];
      ego_lat_vel = req_tdata[127:96];
      oth_lon_pos = req_tdata[159:128];
      oth_lon_vel = req_tdata[191:160];
      oth_lat_pos = req_tdata[223:192];
      oth_lat_vel = req_tdata[255:224];

      d_lon     = {ego_lon_pos[31], ego_lon_pos} - {oth_lon_pos[31], oth_lon_pos};
      d_lat     = {ego_lat_pos[31], ego_lat_pos} - {oth_lat_pos[31], oth_lat_pos};
      d_lon_neg = -d_lon;
      d_lat_neg = -d_lat;

      side_in.ego_lon_neg = ego_lon_vel[31];
      side_in.oth_lon_neg = oth_lon_vel[31];
      side_in.ego_lat_neg = ego_lat_vel[31];
      side_in.oth_lat_neg = oth_lat_vel[31];
      side_in.ego_behind  = d_lon[32];
      side_in.ego_lat_ge  = !d_lat[32];
      side_in.gap_lon     = d_lon[32] ? d_lon_neg[31:0] : d_lon[31:0];
      side_in.gap_lat     = d_lat[32] ? d_lat_neg[31:0] : d_lat[31:0];

      vabs_in[0] = rsdc_pkg::mag_of(ego_lon_vel);
      vabs_in[1] = rsdc_pkg::mag_of(oth_lon_vel);
      vabs_in[2] = rsdc_pkg::mag_of(ego_lat_vel);
      vabs_in[3] = rsdc_pkg::mag_of(oth_lat_vel);

      // speed gained during the response time, shared by both lanes of a direction
      ar_lon_in = rsdc_pkg::mulq(cfg.lon_accel_max, cfg.react_time);
      ar_lat_in = rsdc_pkg::mulq(cfg.lat_accel_max, cfg.react_time);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         side_ff[1] <= side_in;
         vabs_ff    <= vabs_in;
         ar_lon_ff  <= ar_lon_in;
         ar_lat_ff  <= ar_lat_in;
      end
      for (int k = 2; k <= 5; k++) begin
         if (en[k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // ---------------- stages 2 to 5: four distance lanes ----------------
   rsdc_pkg::dist_type ego_lon_dist, oth_lon_dist, ego_lat_dist, oth_lat_dist;

   rsdc_lane u_lane_ego_lon (
      .clock           (clock),
      .stage_en        (en[5:2]),
      .vabs            (vabs_ff[0]),
      .accel_resp      (ar_lon_ff),
      .resp_time       (cfg.react_time),
      .brake_min_recip (cfg.lon_brake_min_half_recip),
      .brake_max_recip (cfg.lon_brake_max_half_recip),
      .stop_dist       (ego_lon_dist)
   );

   rsdc_lane u_lane_oth_lon (
      .clock           (clock),
      .stage_en        (en[5:2]),
      .vabs            (vabs_ff[1]),
      .accel_resp      (ar_lon_ff),
      .resp_time       (cfg.react_time),
      .brake_min_recip (cfg.lon_brake_min_half_recip),
      .brake_max_recip (cfg.lon_brake_max_half_recip),
      .stop_dist       (oth_lon_dist)
   );

   rsdc_lane u_lane_ego_lat (
      .clock           (clock),
      .stage_en        (en[5:2]),
      .vabs            (vabs_ff[2]),
      .accel_resp      (ar_lat_ff),
      .resp_time       (cfg.react_time),
      .brake_min_recip (cfg.lat_brake_min_half_recip),
      .brake_max_recip (cfg.lat_brake_max_half_recip),
      .stop_dist       (ego_lat_dist)
   );

   rsdc_lane u_lane_oth_lat (
      .clock           (clock),
      .stage_en        (en[5:2]),
      .vabs            (vabs_ff[3]),
      .accel_resp      (ar_lat_ff),
      .resp_time       (cfg.react_time),
      .brake_min_recip (cfg.lat_brake_min_half_recip),
      .brake_max_recip (cfg.lat_brake_max_half_recip),
      .stop_dist       (oth_lat_dist)
   );

   // ---------------- stages 6 and 7: selection, margin, verdict ----------------
   rsdc_pkg::result_type result;

   rsdc_decide u_decide (
      .clock      (clock),
      .stage_en   (en[7:6]),
      .side       (side_ff[5]),
      .ego_lon    (ego_lon_dist),
      .oth_lon    (oth_lon_dist),
      .ego_lat    (ego_lat_dist),
      .oth_lat    (oth_lat_dist),
      .lat_margin (cfg.lat_margin),
      .result     (result)
   );

   assign rsp_tdata = {1'b0, result.safe_lat, result.safe_lon, result.is_safe};

   // ---------------- assertions ----------------
   logic req_beat, rsp_beat;
   assign req_beat = req_tvalid && req_tready;
   assign rsp_beat = rsp_tvalid && rsp_tready;

   // beats in flight change only by accepts and deliveries
   a_inflight_count: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> $countones(v_ff) ==
         $countones($past(v_ff)) + int'($past(req_beat)) - int'($past(rsp_beat)))
      else $error("in-flight beat count broken");

   // stalling the input means stage 1 is occupied
   a_stall_occupied: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> v_ff[1])
      else $error("input stalled with empty stage 1");

   // an unsafe verdict needs both safe distances above zero
   a_unsafe_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !result.is_safe |-> result.safe_lon != '0 && result.safe_lat != '0)
      else $error("unsafe verdict with a zero safe distance");

endmodule
